// ===== sv/cawf_pkg.sv =====
// Package for the 8-bit processor ALU with flags.
// Holds command codes, flag bit positions and the result bundle type.
// No dependencies.
`timescale 1ns / 1ps

package cawf_pkg;

  // Operation codes carried in the command field.
  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_XOR   = 5'd5;
  localparam logic [4:0] CMD_OR    = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC   = 5'd8;
  localparam logic [4:0] CMD_DEC   = 5'd9;
  localparam logic [4:0] CMD_RLCA  = 5'd10;
  localparam logic [4:0] CMD_RRCA  = 5'd11;
  localparam logic [4:0] CMD_RLA   = 5'd12;
  localparam logic [4:0] CMD_RRA   = 5'd13;
  localparam logic [4:0] CMD_DAA   = 5'd14;
  localparam logic [4:0] CMD_CPL   = 5'd15;
  localparam logic [4:0] CMD_SCF   = 5'd16;
  localparam logic [4:0] CMD_CCF   = 5'd17;
  localparam logic [4:0] CMD_ADD16 = 5'd18;
  localparam logic [4:0] CMD_ADDSP = 5'd19;

  // Flag bit positions within the 4-bit flag nibble.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LOW_FIX  = 8'h06;
  localparam logic [7:0] DAA_HIGH_FIX = 8'h60;
  localparam logic [7:0] DAA_BCD_MAX  = 8'h99;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

  // One result item.
  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic [3:0]  flags;
  } alu_result_t;

endpackage

// ===== sv/cawf_compute.sv =====
// Combinational datapath of the ALU: one operation per item.
// Depends on cawf_pkg for command codes, flag positions and alu_result_t.
`timescale 1ns / 1ps

module cawf_compute import cawf_pkg::*; (
  input  logic [4:0]  command,
  input  logic [7:0]  acc_in,
  input  logic [3:0]  flags_in,
  input  logic [7:0]  operand,
  input  logic [15:0] wide_left,
  input  logic [15:0] wide_right,
  output alu_result_t res
);

  logic        carry_in;
  logic        add_ci;
  logic        sub_bi;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [7:0]  daa_adj;
  logic        daa_setc;
  logic [7:0]  daa_val;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;

  assign carry_in = flags_in[FLAG_C];

  // Byte adder and subtractor with nibble carries, plus increment and decrement of the operand.
  always_comb begin
    add_ci   = (command == CMD_ADC) ? carry_in : 1'b0;
    sub_bi   = (command == CMD_SBC) ? carry_in : 1'b0;
    add_sum  = {1'b0, acc_in} + {1'b0, operand} + {8'd0, add_ci};
    add_half = {1'b0, acc_in[3:0]} + {1'b0, operand[3:0]} + {4'd0, add_ci};
    sub_diff = {1'b0, acc_in} - {1'b0, operand} - {8'd0, sub_bi};
    sub_half = {1'b0, acc_in[3:0]} - {1'b0, operand[3:0]} - {4'd0, sub_bi};
    inc_val  = operand + 8'd1;
    dec_val  = operand - 8'd1;
  end

  // Decimal adjust: correction depends on the previous operation's N flag.
  always_comb begin
    daa_adj  = 8'd0;
    daa_setc = 1'b0;
    if (!flags_in[FLAG_N]) begin
      if (flags_in[FLAG_H] || (acc_in[3:0] > DAA_DIGIT_MAX)) begin
        daa_adj = daa_adj | DAA_LOW_FIX;
      end
      if (carry_in || (acc_in > DAA_BCD_MAX)) begin
        daa_adj  = daa_adj | DAA_HIGH_FIX;
        daa_setc = 1'b1;
      end
      daa_val = acc_in + daa_adj;
    end else begin
      if (flags_in[FLAG_H]) begin
        daa_adj = daa_adj | DAA_LOW_FIX;
      end
      if (carry_in) begin
        daa_adj  = daa_adj | DAA_HIGH_FIX;
        daa_setc = 1'b1;
      end
      daa_val = acc_in - daa_adj;
    end
  end

  // Wide adders: carries out of bits 11 and 15 for add16, and unsigned
  // low-nibble and low-byte carries for the stack-pointer add.
  always_comb begin
    w_sum   = {1'b0, wide_left} + {1'b0, wide_right};
    w_half  = {1'b0, wide_left[11:0]} + {1'b0, wide_right[11:0]};
    sp_sum  = wide_left + {{8{operand[7]}}, operand};
    sp_half = {1'b0, wide_left[3:0]} + {1'b0, operand[3:0]};
    sp_low  = {1'b0, wide_left[7:0]} + {1'b0, operand};
  end

  // Result and flag selection by command.
  always_comb begin
    res.result_byte = acc_in;
    res.result_word = 16'd0;
    res.flags       = flags_in;
    case (command)
      CMD_ADD, CMD_ADC: begin
        res.result_byte     = add_sum[7:0];
        res.flags           = 4'd0;
        res.flags[FLAG_Z]   = (add_sum[7:0] == 8'd0);
        res.flags[FLAG_H]   = add_half[4];
        res.flags[FLAG_C]   = add_sum[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (command != CMD_CP) begin
          res.result_byte = sub_diff[7:0];
        end
        res.flags           = 4'd0;
        res.flags[FLAG_N]   = 1'b1;
        res.flags[FLAG_Z]   = (sub_diff[7:0] == 8'd0);
        res.flags[FLAG_H]   = sub_half[4];
        res.flags[FLAG_C]   = sub_diff[8];
      end
      CMD_AND: begin
        res.result_byte   = acc_in & operand;
        res.flags         = 4'd0;
        res.flags[FLAG_H] = 1'b1;
        res.flags[FLAG_Z] = ((acc_in & operand) == 8'd0);
      end
      CMD_XOR: begin
        res.result_byte   = acc_in ^ operand;
        res.flags         = 4'd0;
        res.flags[FLAG_Z] = ((acc_in ^ operand) == 8'd0);
      end
      CMD_OR: begin
        res.result_byte   = acc_in | operand;
        res.flags         = 4'd0;
        res.flags[FLAG_Z] = ((acc_in | operand) == 8'd0);
      end
      CMD_INC: begin
        res.result_byte   = inc_val;
        res.flags[FLAG_Z] = (inc_val == 8'd0);
        res.flags[FLAG_N] = 1'b0;
        res.flags[FLAG_H] = (operand[3:0] == 4'hF);
      end
      CMD_DEC: begin
        res.result_byte   = dec_val;
        res.flags[FLAG_Z] = (dec_val == 8'd0);
        res.flags[FLAG_N] = 1'b1;
        res.flags[FLAG_H] = (operand[3:0] == 4'h0);
      end
      CMD_RLCA: begin
        res.result_byte   = {acc_in[6:0], acc_in[7]};
        res.flags         = 4'd0;
        res.flags[FLAG_C] = acc_in[7];
      end
      CMD_RRCA: begin
        res.result_byte   = {acc_in[0], acc_in[7:1]};
        res.flags         = 4'd0;
        res.flags[FLAG_C] = acc_in[0];
      end
      CMD_RLA: begin
        res.result_byte   = {acc_in[6:0], carry_in};
        res.flags         = 4'd0;
        res.flags[FLAG_C] = acc_in[7];
      end
      CMD_RRA: begin
        res.result_byte   = {carry_in, acc_in[7:1]};
        res.flags         = 4'd0;
        res.flags[FLAG_C] = acc_in[0];
      end
      CMD_DAA: begin
        res.result_byte   = daa_val;
        res.flags         = 4'd0;
        res.flags[FLAG_N] = flags_in[FLAG_N];
        res.flags[FLAG_Z] = (daa_val == 8'd0);
        res.flags[FLAG_C] = daa_setc;
      end
      CMD_CPL: begin
        res.result_byte   = ~acc_in;
        res.flags[FLAG_N] = 1'b1;
        res.flags[FLAG_H] = 1'b1;
      end
      CMD_SCF: begin
        res.flags         = 4'd0;
        res.flags[FLAG_Z] = flags_in[FLAG_Z];
        res.flags[FLAG_C] = 1'b1;
      end
      CMD_CCF: begin
        res.flags         = 4'd0;
        res.flags[FLAG_Z] = flags_in[FLAG_Z];
        res.flags[FLAG_C] = ~carry_in;
      end
      CMD_ADD16: begin
        res.result_word   = w_sum[15:0];
        res.flags         = 4'd0;
        res.flags[FLAG_Z] = flags_in[FLAG_Z];
        res.flags[FLAG_H] = w_half[12];
        res.flags[FLAG_C] = w_sum[16];
      end
      CMD_ADDSP: begin
        res.result_word   = sp_sum;
        res.flags         = 4'd0;
        res.flags[FLAG_H] = sp_half[4];
        res.flags[FLAG_C] = sp_low[8];
      end
      default: begin
        // Unused codes pass the accumulator and flags through.
        res.result_byte = acc_in;
        res.result_word = 16'd0;
        res.flags       = flags_in;
      end
    endcase
  end

endmodule

// ===== sv/cpu_alu_with_flags_core.sv =====
// A taken item passes the input register, then the result register,
// before its result appears on done. Throughput: one item per cycle;
// busy is always low and the receiver cannot stall.
// Reset (rst, synchronous, active high) clears the valid bits of both
// stages, so no result strobe follows reset; data registers are not reset.
// Top level of the ALU; depends on cawf_pkg and cawf_compute.
`timescale 1ns / 1ps

module cpu_alu_with_flags_core import cawf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  command,
  input  logic [7:0]  acc_in,
  input  logic [3:0]  flags_in,
  input  logic [7:0]  operand,
  input  logic [15:0] wide_left,
  input  logic [15:0] wide_right,
  output logic        done,
  output logic [7:0]  result_byte,
  output logic [15:0] result_word,
  output logic [3:0]  flags_out
);

  logic        in_valid;
  logic [4:0]  cmd_q;
  logic [7:0]  acc_q;
  logic [3:0]  flags_q;
  logic [7:0]  operand_q;
  logic [15:0] wide_left_q;
  logic [15:0] wide_right_q;
  alu_result_t res_next;

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy = 1'b0;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q        <= command;
      acc_q        <= acc_in;
      flags_q      <= flags_in;
      operand_q    <= operand;
      wide_left_q  <= wide_left;
      wide_right_q <= wide_right;
    end
  end

  // Operation datapath.
  cawf_compute u_compute (
    .command    (cmd_q),
    .acc_in     (acc_q),
    .flags_in   (flags_q),
    .operand    (operand_q),
    .wide_left  (wide_left_q),
    .wide_right (wide_right_q),
    .res        (res_next)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result_byte <= res_next.result_byte;
      result_word <= res_next.result_word;
      flags_out   <= res_next.flags;
    end
  end

endmodule

// ===== sv/cawf_checker.sv =====
// Port-level checks for cpu_alu_with_flags_core, bound to the top level.
// Depends on cawf_pkg for command codes.
`timescale 1ns / 1ps

module cawf_checker import cawf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  command,
  input logic [7:0]  acc_in,
  input logic        done,
  input logic [7:0]  result_byte,
  input logic [15:0] result_word
);

  // Every accepted item yields a result strobe on done.
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  // No result strobe on done without an item taken before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !start |=> ##1 !done)
    else $error("result strobe without an item");

  // Compare leaves the accumulator untouched.
  a_cp_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command, 2) == CMD_CP)) |-> (result_byte == $past(acc_in, 2)))
    else $error("compare changed the accumulator");

  // The word result is zero except for the two wide additions.
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command, 2) != CMD_ADD16) && ($past(command, 2) != CMD_ADDSP))
      |-> (result_word == 16'd0))
    else $error("word result not zero for a byte operation");

  // Reset leaves no result strobe behind.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind cpu_alu_with_flags_core cawf_checker u_cawf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .acc_in      (acc_in),
  .done        (done),
  .result_byte (result_byte),
  .result_word (result_word)
);
